// ----- rtl/core/gmrm_pkg.sv -----
// Shared types and constants of the gain mixer and RMS meter.
package gmrm_pkg;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 64;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_MASK = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_LOW = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_HIGH = 2'd2;
	localparam int MAX_CH = 8;
	localparam int GAIN_BITS = 16;
	localparam int ACC_BITS = 59;
	localparam int METER_BITS = 11;
	localparam logic [METER_BITS-1:0] METER_TOP = 11'd1024;
	localparam logic [22:0] METER_K = 23'd3366964;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DIV,
		ST_ACC,
		ST_MDIV,
		ST_LOG,
		ST_METER,
		ST_OUT
	} state_t;
endpackage

// ----- rtl/core/gmrm_in_if.sv -----
// Input frame channel: eight samples and the block end flag.
interface gmrm_in_if #(parameter int SAMPLE_BITS = 24);
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] sample_ch0;
	logic signed [SAMPLE_BITS-1:0] sample_ch1;
	logic signed [SAMPLE_BITS-1:0] sample_ch2;
	logic signed [SAMPLE_BITS-1:0] sample_ch3;
	logic signed [SAMPLE_BITS-1:0] sample_ch4;
	logic signed [SAMPLE_BITS-1:0] sample_ch5;
	logic signed [SAMPLE_BITS-1:0] sample_ch6;
	logic signed [SAMPLE_BITS-1:0] sample_ch7;
	logic block_end;
	modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		sample_ch4, sample_ch5, sample_ch6, sample_ch7, block_end, input ready);
	modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		sample_ch4, sample_ch5, sample_ch6, sample_ch7, block_end, output ready);
endinterface

// ----- rtl/core/gmrm_out_if.sv -----
// Result channel: mix sample and meter reading.
interface gmrm_out_if #(parameter int SAMPLE_BITS = 24);
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] mix_sample;
	logic meter_valid;
	logic [10:0] meter_level;
	modport source (output valid, mix_sample, meter_valid, meter_level, input ready);
	modport sink (input valid, mix_sample, meter_valid, meter_level, output ready);
endinterface

// ----- rtl/core/gmrm_divider.sv -----
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module gmrm_divider #(
	parameter int N_BITS = 64,
	parameter int D_BITS = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [N_BITS-1:0] num,
	input  logic [D_BITS-1:0] den,
	output logic              done,
	output logic [N_BITS-1:0] quot
);
	localparam int CNT_BITS = $clog2(N_BITS + 1);
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic [N_BITS-1:0] q_q;
	logic [D_BITS-1:0] den_q;
	logic [D_BITS:0] r_q;
	logic [D_BITS:0] trial;
	logic [D_BITS:0] diff;

	always_comb begin
		trial = {r_q[D_BITS-1:0], q_q[N_BITS-1]};
		diff = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(N_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			den_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			if (!diff[D_BITS]) begin
				r_q <= diff;
				q_q <= {q_q[N_BITS-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[N_BITS-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule

// ----- rtl/core/gain_mixer_rms_meter.sv -----
// Top level of the eight-channel gain mixer with block RMS meter.
// One frame is processed at a time. The channel products go through one shared
// SAMPLE_BITS x 16 multiplier, one channel per cycle; the normalizing division and
// the mean-square division run on a 64-bit bit-serial divider, and the log2 fraction
// takes sixteen squarings on a 32x32 multiplier, one per cycle. A block_end frame
// adds the mean division, the log2 and the meter mapping to the frame's work. The
// result sits in its own output register, so a new request is taken while it waits;
// the block stalls only in its last state when the previous result is still unread.
module gain_mixer_rms_meter #(
	parameter int CHANNELS = 8,
	parameter int SAMPLE_BITS = 24,
	parameter int MAX_BLOCK = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [gmrm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [gmrm_pkg::CFG_DATA_BITS-1:0] cfg_data,
	gmrm_in_if.sink frame_in,
	gmrm_out_if.source mix_out
);
	import gmrm_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
	localparam int TOT_BITS = PROD_BITS + 3;
	localparam int MAG_BITS = TOT_BITS;
	localparam int DEN_BITS = 18;
	localparam int CH_BITS = 3;
	localparam int FC_BITS = $clog2(MAX_BLOCK + 1);
	localparam int SQ_BITS = 2 * SAMPLE_BITS;
	localparam int FS = 2 * (SAMPLE_BITS - 1);
	localparam int DIV_N = 64;
	localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

	state_t state_q, state_d;
	logic [7:0] mask_q;
	logic [63:0] glo_q, ghi_q;
	logic signed [SAMPLE_BITS-1:0] smp_q [MAX_CH];
	logic be_q;
	logic [CH_BITS:0] ch_q;
	logic [3:0] n_q;
	logic signed [TOT_BITS-1:0] tot_q;
	logic [ACC_BITS-1:0] sum_q;
	logic [FC_BITS-1:0] fc_q;
	logic signed [SAMPLE_BITS-1:0] mix_q;
	logic [METER_BITS-1:0] lvl_q;
	logic [63:0] mean_q;
	logic [5:0] lpos_q;
	logic [32:0] m_q;
	logic [4:0] it_q;
	logic [15:0] frac_q;
	logic ovalid_q;
	logic div_start_q;
	logic signed [SAMPLE_BITS-1:0] omix_q;
	logic omv_q;
	logic [METER_BITS-1:0] olvl_q;

	// Channel product, one per cycle.
	logic [CH_BITS-1:0] ch_idx;
	logic signed [GAIN_BITS-1:0] gain_c;
	logic signed [PROD_BITS-1:0] prod;
	logic mac_en;
	always_comb begin
		ch_idx = ch_q[CH_BITS-1:0];
		gain_c = ch_idx[2] ? ghi_q[16*ch_idx[1:0] +: 16] : glo_q[16*ch_idx[1:0] +: 16];
		prod = smp_q[ch_idx] * gain_c;
		mac_en = mask_q[ch_idx] && (ch_q < (CH_BITS+1)'(CHANNELS));
	end

	// Shared divider.
	logic [DIV_N-1:0] div_num;
	logic [DEN_BITS-1:0] div_den;
	logic div_done;
	logic [DIV_N-1:0] div_quot;
	logic [MAG_BITS-1:0] mag;
	always_comb begin
		mag = tot_q[TOT_BITS-1] ? MAG_BITS'(-tot_q) : MAG_BITS'(tot_q);
		if (state_q == ST_DIV) begin
			div_num = DIV_N'(mag) + DIV_N'({n_q, 13'd0});
			div_den = DEN_BITS'({n_q, 14'd0});
		end else begin
			div_num = DIV_N'(sum_q);
			div_den = DEN_BITS'(fc_q);
		end
	end

	gmrm_divider #(.N_BITS(DIV_N), .D_BITS(DEN_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot)
	);

	// Saturated signed mix from the quotient.
	logic [SAMPLE_BITS-1:0] smax;
	logic signed [SAMPLE_BITS-1:0] mix_d;
	always_comb begin
		smax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		if (n_q == 4'd0) begin
			mix_d = '0;
		end else if (!tot_q[TOT_BITS-1]) begin
			mix_d = (div_quot > DIV_N'(smax)) ? smax : div_quot[SAMPLE_BITS-1:0];
		end else begin
			mix_d = (div_quot > DIV_N'(smax) + 1) ? ~smax
				: SAMPLE_BITS'(-div_quot[SAMPLE_BITS-1:0]);
		end
	end

	logic [SQ_BITS-1:0] sq;
	logic [ACC_BITS:0] acc_sum;
	always_comb begin
		sq = $signed(mix_q) * $signed(mix_q);
		acc_sum = {1'b0, sum_q} + (ACC_BITS+1)'(sq);
	end

	// Leading one and normalized mantissa of the mean.
	logic [5:0] lead;
	logic [63:0] norm;
	always_comb begin
		lead = '0;
		for (int i = 0; i < 64; i++) begin
			if (div_quot[i]) lead = 6'(i);
		end
		norm = (lead >= 6'd31) ? (div_quot >> (lead - 6'd31)) : (div_quot << (6'd31 - lead));
	end

	logic [63:0] msq;
	logic [32:0] msh;
	always_comb begin
		msq = m_q[31:0] * m_q[31:0];
		msh = 33'(msq >> 31);
	end

	logic signed [23:0] xl;
	logic signed [47:0] macc;
	logic [METER_BITS-1:0] meter_d;
	always_comb begin
		xl = $signed({2'b0, lpos_q, frac_q}) - 24'(FS << 16);
		macc = $signed({1'b0, METER_TOP, 32'd0}) + $signed({1'b0, METER_K}) * xl;
		if (mean_q == 64'd0 || macc <= 0) meter_d = '0;
		else if ((macc >>> 32) > 48'(METER_TOP)) meter_d = METER_TOP;
		else meter_d = METER_BITS'(macc >>> 32);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (frame_in.valid) state_d = ST_MAC;
			ST_MAC: if (ch_q == (CH_BITS+1)'(MAX_CH - 1)) state_d = ST_DIV;
			ST_DIV: if (div_done) state_d = ST_ACC;
			ST_ACC: state_d = be_q ? ST_MDIV : ST_OUT;
			ST_MDIV: if (div_done) state_d = ST_LOG;
			ST_LOG: if (it_q == 5'd16) state_d = ST_METER;
			ST_METER: state_d = ST_OUT;
			ST_OUT: if (!ovalid_q || mix_out.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		frame_in.ready = (state_q == ST_IDLE);
		mix_out.valid = ovalid_q;
		mix_out.mix_sample = omix_q;
		mix_out.meter_valid = omv_q;
		mix_out.meter_level = olvl_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mask_q <= 8'hFF;
			glo_q <= 64'h4000400040004000;
			ghi_q <= 64'h4000400040004000;
			sum_q <= '0;
			fc_q <= '0;
			ovalid_q <= 1'b0;
			div_start_q <= 1'b0;
			omix_q <= '0;
			omv_q <= 1'b0;
			olvl_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_ACTIVE_MASK: mask_q <= cfg_data[7:0];
					REG_GAIN_LOW: glo_q <= cfg_data;
					REG_GAIN_HIGH: ghi_q <= cfg_data;
					default: ;
				endcase
			end
			div_start_q <= (state_q == ST_MAC && state_d == ST_DIV)
				|| (state_q == ST_ACC && be_q);
			if (state_q == ST_ACC) begin
				if (fc_q < FC_BITS'(MAX_BLOCK)) begin
					sum_q <= acc_sum[ACC_BITS] ? ACC_MAX : acc_sum[ACC_BITS-1:0];
					fc_q <= fc_q + 1'b1;
				end
			end
			if (state_q == ST_METER) begin
				sum_q <= '0;
				fc_q <= '0;
			end
			// A new result replaces the old one in the same cycle that the old one is taken.
			if (state_q == ST_OUT && state_d == ST_IDLE) begin
				ovalid_q <= 1'b1;
				omix_q <= mix_q;
				omv_q <= be_q;
				olvl_q <= be_q ? lvl_q : '0;
			end else if (mix_out.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Frame datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				smp_q[0] <= frame_in.sample_ch0;
				smp_q[1] <= frame_in.sample_ch1;
				smp_q[2] <= frame_in.sample_ch2;
				smp_q[3] <= frame_in.sample_ch3;
				smp_q[4] <= frame_in.sample_ch4;
				smp_q[5] <= frame_in.sample_ch5;
				smp_q[6] <= frame_in.sample_ch6;
				smp_q[7] <= frame_in.sample_ch7;
				be_q <= frame_in.block_end;
				ch_q <= '0;
				n_q <= '0;
				tot_q <= '0;
				lvl_q <= '0;
			end
			ST_MAC: begin
				if (mac_en) begin
					tot_q <= tot_q + TOT_BITS'(prod);
					n_q <= n_q + 1'b1;
				end
				ch_q <= ch_q + 1'b1;
			end
			ST_DIV: if (div_done) mix_q <= mix_d;
			ST_MDIV: begin
				if (div_done) begin
					mean_q <= (fc_q == '0) ? 64'd0 : div_quot;
					lpos_q <= lead;
					m_q <= 33'(norm);
					it_q <= '0;
					frac_q <= '0;
				end
			end
			ST_LOG: begin
				if (it_q != 5'd16) begin
					it_q <= it_q + 1'b1;
					if (msh[32]) begin
						frac_q <= {frac_q[14:0], 1'b1};
						m_q <= {1'b0, msh[32:1]};
					end else begin
						frac_q <= {frac_q[14:0], 1'b0};
						m_q <= msh;
					end
				end
			end
			ST_METER: lvl_q <= meter_d;
			default: ;
		endcase
	end
endmodule

// ----- dv/tb.sv -----
// Self-checking testbench of the gain mixer and RMS meter.
module tb;
	import gmrm_pkg::*;

	localparam int SBITS = 24;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam longint unsigned SUM_MAX = (64'd1 << ACC_BITS) - 64'd1;
	localparam int BLOCK_LIMIT = 4096;

	typedef struct {
		logic signed [SBITS-1:0] smp [MAX_CH];
		bit blk_end;
	} frame_t;

	typedef struct {
		logic signed [SBITS-1:0] mix;
		bit mv;
		logic [METER_BITS-1:0] level;
	} mix_result_t;

	typedef struct {
		frame_t f;
		bit typed;
		mix_result_t res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	gmrm_in_if #(.SAMPLE_BITS(SBITS)) frame_in ();
	gmrm_out_if #(.SAMPLE_BITS(SBITS)) mix_out ();

	gain_mixer_rms_meter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.frame_in(frame_in.sink),
		.mix_out(mix_out.source)
	);

	// Mirror of the block's registers and metering state.
	logic [7:0] mask_q;
	logic [63:0] gain_lo_q;
	logic [63:0] gain_hi_q;
	longint unsigned sq_sum_q;
	int frames_q;

	mix_result_t pending_mix[$];
	dir_row_t dir_rows[$];
	int errors = 0;
	bit idle_en = 1'b1;
	bit hold_req = 1'b0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint unsigned log2_fix(longint unsigned v);
		int p;
		longint unsigned m;
		longint unsigned fr;
		p = 0;
		fr = 0;
		for (int i = 0; i < 64; i++)
			if (v[i]) p = i;
		m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			fr = fr << 1;
			if (m >= 64'h1_0000_0000) begin
				fr = fr | 64'd1;
				m = m >> 1;
			end
		end
		return (longint'(p) << 16) | fr;
	endfunction

	function automatic logic [METER_BITS-1:0] level_of(longint unsigned mean);
		longint x;
		longint acc;
		if (mean == 0) return '0;
		x = longint'(log2_fix(mean)) - (longint'(2 * (SBITS - 1)) << 16);
		acc = (longint'(1024) << 32) + longint'(METER_K) * x;
		if (acc <= 0) return '0;
		acc = acc >>> 32;
		if (acc > 1024) return METER_TOP;
		return acc[METER_BITS-1:0];
	endfunction

	// Works out the result of one frame and advances the metering state.
	function automatic mix_result_t mix_and_meter(frame_t f);
		mix_result_t r;
		longint total;
		longint d;
		longint mag;
		longint q;
		longint mix;
		longint unsigned sq;
		logic signed [GAIN_BITS-1:0] g;
		int n;
		total = 0;
		n = 0;
		mix = 0;
		for (int c = 0; c < MAX_CH; c++) begin
			g = (c < 4) ? gain_lo_q[16*c +: 16] : gain_hi_q[16*(c-4) +: 16];
			if (mask_q[c]) begin
				total += longint'(f.smp[c]) * longint'(g);
				n++;
			end
		end
		if (n > 0) begin
			d = longint'(n) << 14;
			mag = (total < 0) ? -total : total;
			q = (mag + d / 2) / d;
			mix = (total < 0) ? -q : q;
		end
		if (mix > 64'sd8388607) mix = 64'sd8388607;
		if (mix < -64'sd8388608) mix = -64'sd8388608;
		if (frames_q < BLOCK_LIMIT) begin
			sq = longint'(mix * mix);
			sq_sum_q = (sq_sum_q > SUM_MAX - sq) ? SUM_MAX : sq_sum_q + sq;
			frames_q++;
		end
		r.mix = mix[SBITS-1:0];
		r.mv = f.blk_end;
		r.level = '0;
		if (f.blk_end) begin
			r.level = level_of((frames_q > 0) ? sq_sum_q / longint'(frames_q) : 0);
			sq_sum_q = 0;
			frames_q = 0;
		end
		return r;
	endfunction

	function automatic logic signed [SBITS-1:0] rand_sample();
		case ($urandom_range(5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return $signed(24'($urandom_range(511))) - 24'sd256;
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic frame_t rand_frame(int be_pct);
		frame_t f;
		for (int c = 0; c < MAX_CH; c++) f.smp[c] = rand_sample();
		f.blk_end = ($urandom_range(99) < be_pct);
		return f;
	endfunction

	// Even channels get a, odd channels get b.
	function automatic dir_row_t row(int a, int b, bit be, bit typed, int m, bit mv, int lvl);
		dir_row_t r;
		for (int c = 0; c < MAX_CH; c++) r.f.smp[c] = (c % 2) ? b[SBITS-1:0] : a[SBITS-1:0];
		r.f.blk_end = be;
		r.typed = typed;
		r.res.mix = m[SBITS-1:0];
		r.res.mv = mv;
		r.res.level = lvl[METER_BITS-1:0];
		return r;
	endfunction

	// Presents one request and returns at the edge that accepts it.
	task automatic send_frame(frame_t f, bit typed, mix_result_t typed_res);
		mix_result_t r;
		while (idle_en && $urandom_range(99) < 15) begin
			frame_in.valid <= 1'b0;
			@(posedge clk);
		end
		frame_in.valid <= 1'b1;
		frame_in.sample_ch0 <= f.smp[0];
		frame_in.sample_ch1 <= f.smp[1];
		frame_in.sample_ch2 <= f.smp[2];
		frame_in.sample_ch3 <= f.smp[3];
		frame_in.sample_ch4 <= f.smp[4];
		frame_in.sample_ch5 <= f.smp[5];
		frame_in.sample_ch6 <= f.smp[6];
		frame_in.sample_ch7 <= f.smp[7];
		frame_in.block_end <= f.blk_end;
		do @(posedge clk); while (!frame_in.ready);
		r = mix_and_meter(f);
		pending_mix.insert(pending_mix.size(), typed ? typed_res : r);
	endtask

	task automatic drain();
		frame_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_mix.size() > 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ACTIVE_MASK) mask_q = val[7:0];
		else if (idx == REG_GAIN_LOW) gain_lo_q = val;
		else if (idx == REG_GAIN_HIGH) gain_hi_q = val;
		@(posedge clk);
	endtask

	function automatic logic [63:0] gain_word(int sel);
		logic [63:0] w;
		for (int i = 0; i < 4; i++)
			case (sel)
				0: w[16*i +: 16] = 16'h7FFF;
				1: w[16*i +: 16] = 16'h8000;
				2: w[16*i +: 16] = 16'h0000;
				3: w[16*i +: 16] = 16'h4000;
				default: w[16*i +: 16] = 16'($urandom());
			endcase
		return w;
	endfunction

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		mix_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				mix_out.ready <= 1'b0;
			end else
				mix_out.ready <= !(idle_en && $urandom_range(99) < 15);
		end
	end

	always @(posedge clk) begin
		mix_result_t e;
		if (arst_n && mix_out.valid && mix_out.ready) begin
			if (pending_mix.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result mix=%0d", mix_out.mix_sample);
			end else begin
				e = pending_mix.pop_front();
				if (mix_out.mix_sample !== e.mix || mix_out.meter_valid !== e.mv
						|| mix_out.meter_level !== e.level) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected mix=%0d mv=%0b lvl=%0d, got mix=%0d mv=%0b lvl=%0d",
							e.mix, e.mv, e.level, mix_out.mix_sample,
							mix_out.meter_valid, mix_out.meter_level);
				end
			end
		end
	end

	initial begin
		mix_result_t none;
		int phase_items;
		none = '{mix: '0, mv: 1'b0, level: '0};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ACTIVE_MASK;
		cfg_data <= '0;
		frame_in.valid <= 1'b0;
		frame_in.sample_ch0 <= '0;
		frame_in.sample_ch1 <= '0;
		frame_in.sample_ch2 <= '0;
		frame_in.sample_ch3 <= '0;
		frame_in.sample_ch4 <= '0;
		frame_in.sample_ch5 <= '0;
		frame_in.sample_ch6 <= '0;
		frame_in.sample_ch7 <= '0;
		frame_in.block_end <= 1'b0;
		mask_q = 8'hFF;
		gain_lo_q = 64'h4000400040004000;
		gain_hi_q = 64'h4000400040004000;
		sq_sum_q = 0;
		frames_q = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at the reset settings, unity gain on all channels.
		dir_rows.insert(dir_rows.size(), row(0, 0, 1, 1, 0, 1, 0));
		dir_rows.insert(dir_rows.size(), row(8388607, 8388607, 0, 1, 8388607, 0, 0));
		dir_rows.insert(dir_rows.size(), row(-8388608, -8388608, 0, 1, -8388608, 0, 0));
		dir_rows.insert(dir_rows.size(), row(8388607, 8388607, 1, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), row(8388607, -8388608, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), row(4, 0, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), row(-4, 0, 1, 0, 0, 0, 0));
		// A mix of one half rounds away from zero.
		dir_rows.insert(dir_rows.size(), row(1, 0, 1, 1, 1, 1, 0));
		dir_rows.insert(dir_rows.size(), row(1000, -3, 1, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), row(-5592405, 2796202, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), row(838860, 838860, 1, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), row(8388, 8388, 1, 0, 0, 0, 0));
		foreach (dir_rows[i]) send_frame(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].res);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: write_reg(REG_ACTIVE_MASK, 64'h0);
				1: write_reg(REG_ACTIVE_MASK, 64'hFF);
				2: write_reg(REG_ACTIVE_MASK, 64'h01);
				3: write_reg(REG_ACTIVE_MASK, 64'h80);
				default: write_reg(REG_ACTIVE_MASK, 64'($urandom()));
			endcase
			write_reg(REG_GAIN_LOW, gain_word(ph < 4 ? ph : 4));
			write_reg(REG_GAIN_HIGH, gain_word(ph < 4 ? ph : 4));
			if (ph == 6) write_reg(REG_UNUSED, 64'h0);
			idle_en = (ph != 5);
			phase_items = 120;
			for (int i = 0; i < phase_items; i++) begin
				if (ph == 2 && i == 10) hold_req = 1'b1;
				if (ph == 4 && i == 60) begin
					frame_in.valid <= 1'b0;
					@(posedge clk);
					while (pending_mix.size() > 0) @(posedge clk);
				end
				send_frame(rand_frame(12), 1'b0, none);
			end
			drain();
		end

		frame_in.valid <= 1'b0;
		while (pending_mix.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_mix.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
